// ----- sv/bsa_pkg.sv -----
// Shared types and constants for the bitmap slot allocator.
// Used by bsa_pool and bitmap_slot_allocator; depends on nothing else.
`timescale 1ns / 1ps

package bsa_pkg;

  // Bitmap memories hold this many slot bits per row.
  localparam int WORD_W  = 64;
  localparam int WORD_SH = 6;

  localparam int CMD_W    = 2;
  localparam int BIDX_IN_W = 10;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 10;
  localparam int ICNT_W   = 8;
  localparam int BCNT_W   = 11;
  localparam int ILIM_REG_W = 9;
  localparam int BLIM_REG_W = 11;
  localparam int CFG_W    = 11;

  localparam logic [ICNT_W-1:0] INODE_CNT_MAX = 8'd255;
  localparam logic [BCNT_W-1:0] BLOCK_CNT_MAX = 11'd2047;

  localparam logic [ILIM_REG_W-1:0] INODE_LIMIT_RST = 9'd256;
  localparam logic [BLIM_REG_W-1:0] BLOCK_LIMIT_RST = 11'd1024;
  localparam logic [ICNT_W-1:0] INODE_CNT_RST = 8'd255;
  localparam logic [BCNT_W-1:0] BLOCK_CNT_RST = 11'd1024;

  // Configuration register indexes.
  localparam logic CFG_INODE_LIMIT = 1'b0;
  localparam logic CFG_BLOCK_LIMIT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_INODE = 2'd0,
    CMD_ALLOC_BLOCK = 2'd1,
    CMD_FREE_BLOCK  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [BIDX_IN_W-1:0] block_index;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_index;
    logic [ICNT_W-1:0]   free_inodes;
    logic [BCNT_W-1:0]   free_blocks;
  } out_word_t;

  // Command from the top level to one bitmap pool.
  typedef struct packed {
    logic start;
    logic free_op;
  } pool_req_t;

  // Status from a pool back to the top level.
  typedef struct packed {
    logic ready;
    logic done;
    logic ok;
  } pool_rsp_t;

  // Position of the lowest set bit; zero when none is set.
  function automatic logic [WORD_SH-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [WORD_SH-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_SH'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- sv/bsa_pool.sv -----
// One bitmap pool: a row-wide used-bit memory with a first-fit scanner and a free path.
// Clears its memory after reset. Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_pool #(
  parameter int SLOTS = 256,
  parameter int FIRST = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bsa_pkg::pool_req_t                    req,
  input  logic [$clog2(SLOTS + 1)-1:0]          limit,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] index,
  output bsa_pkg::pool_rsp_t                    rsp,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] grant_index
);
  import bsa_pkg::*;

  localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RCNT_W = $clog2(ROWS + 1);
  localparam int LIM_W  = $clog2(SLOTS + 1);
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IX_W   = IDX_W + WORD_SH;
  localparam int LX_W   = LIM_W + WORD_SH;
  localparam int CMP_W  = (LX_W > RCNT_W) ? LX_W : RCNT_W;
  localparam int GX_W   = RCNT_W + WORD_SH;

  typedef enum logic [3:0] {
    P_CLEAR = 4'b0001,
    P_IDLE  = 4'b0010,
    P_SCAN  = 4'b0100,
    P_FREE  = 4'b1000
  } pool_state_t;

  pool_state_t state, state_next;
  logic [RCNT_W-1:0] row, row_next;
  logic [WORD_SH-1:0] free_bit;
  logic [WORD_W-1:0] mem [0:ROWS-1];
  logic [WORD_W-1:0] rd_data;
  logic done, ok;

  logic [ROW_W-1:0]  rd_addr, wr_addr;
  logic              mem_we;
  logic [WORD_W-1:0] wr_data;

  logic [LX_W-1:0]   lim_x, rows_used, full_rows;
  logic [WORD_SH-1:0] tail;
  logic [CMP_W-1:0]  row_x;
  logic [WORD_W-1:0] elig, avail;
  logic              hit, scan_end;
  logic [WORD_SH-1:0] bit_sel;
  logic [RCNT_W-1:0] row_inc;
  logic [IX_W-1:0]   index_x;
  logic [GX_W-1:0]   grant_x;

  assign lim_x     = LX_W'(limit);
  assign rows_used = (lim_x + LX_W'(WORD_W - 1)) >> WORD_SH;
  assign full_rows = lim_x >> WORD_SH;
  assign tail      = lim_x[WORD_SH-1:0];
  assign row_x     = CMP_W'(row);
  assign row_inc   = row + RCNT_W'(1);
  assign index_x   = IX_W'(index);

  // Slots of the current row that lie inside the pool's usable range.
  always_comb begin
    if (row_x < CMP_W'(full_rows)) begin
      elig = '1;
    end else if (row_x == CMP_W'(full_rows)) begin
      elig = (WORD_W'(1) << tail) - WORD_W'(1);
    end else begin
      elig = '0;
    end
    if (row == '0) begin
      elig = elig & ~((WORD_W'(1) << FIRST) - WORD_W'(1));
    end
  end

  assign avail    = ~rd_data & elig;
  assign hit      = |avail;
  assign bit_sel  = first_set(avail);
  assign scan_end = row_x >= CMP_W'(rows_used);
  assign grant_x  = (GX_W'(row) << WORD_SH) | GX_W'(bit_sel);

  // Reads run one row ahead of the check, so a scan covers one row a cycle.
  always_comb begin
    rd_addr    = '0;
    mem_we     = 1'b0;
    wr_addr    = ROW_W'(row);
    wr_data    = '0;
    state_next = state;
    row_next   = row;
    case (state)
      P_CLEAR: begin
        mem_we = 1'b1;
        row_next = row_inc;
        if (row_inc == RCNT_W'(ROWS)) begin
          state_next = P_IDLE;
        end
      end
      P_IDLE: begin
        if (req.start) begin
          if (req.free_op) begin
            rd_addr    = ROW_W'(index_x >> WORD_SH);
            row_next   = RCNT_W'(index_x >> WORD_SH);
            state_next = P_FREE;
          end else begin
            row_next   = '0;
            state_next = P_SCAN;
          end
        end
      end
      P_SCAN: begin
        if (row_inc < RCNT_W'(ROWS)) begin
          rd_addr = ROW_W'(row_inc);
        end
        if (scan_end) begin
          state_next = P_IDLE;
        end else if (hit) begin
          mem_we     = 1'b1;
          wr_data    = rd_data | (WORD_W'(1) << bit_sel);
          state_next = P_IDLE;
        end else begin
          row_next = row_inc;
        end
      end
      P_FREE: begin
        mem_we     = rd_data[free_bit];
        wr_data    = rd_data & ~(WORD_W'(1) << free_bit);
        state_next = P_IDLE;
      end
      default: begin
        state_next = P_CLEAR;
        row_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_CLEAR;
      row   <= '0;
      done  <= 1'b0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      row   <= row_next;
      done  <= 1'b0;
      if (state == P_SCAN && (scan_end || hit)) begin
        done <= 1'b1;
        ok   <= !scan_end;
      end
      if (state == P_FREE) begin
        done <= 1'b1;
        ok   <= rd_data[free_bit];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == P_IDLE && req.start) begin
      free_bit <= index_x[WORD_SH-1:0];
    end
    if (state == P_SCAN && !scan_end && hit) begin
      grant_index <= IDX_W'(grant_x);
    end
  end

  assign rsp.ready = (state == P_IDLE);
  assign rsp.done  = done;
  assign rsp.ok    = ok;

endmodule

// ----- sv/bitmap_slot_allocator.sv -----
// Top level of the two-pool first-fit bitmap allocator.
// Holds the limit registers, the free counts and the output register; uses bsa_pool, bsa_pkg.
//
// Usage: a command word (allocate inode, allocate block, free block) enters on in_valid
// while in_stall is low; one result word leaves on out_valid and is held until out_stall
// is low. Commands run one at a time. Each pool keeps its used bits in a memory of 64-bit
// rows with registered reads; an allocation checks one row per cycle from row 0 up to the
// first row with a free slot, checking 1 to 4 rows for inodes and 1 to 16 for blocks at
// the default sizes, one more when the pool is full, before its result is registered. A
// block free reads and writes one row. An out-of-range free or an unknown command answers
// without using a pool.
// The next command may be taken while the previous result still waits in the output
// register. After reset both bitmaps are cleared one row per cycle, during which in_stall
// is high. Limit writes reload the matching free count; the user must make them only while
// the block is idle, and the block itself does not enforce this. A stalled output holds
// its word and the block finishes at most one more command before it stalls its input.
`timescale 1ns / 1ps

module bitmap_slot_allocator #(
  parameter int INODE_SLOTS = 256,
  parameter int BLOCK_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bsa_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bsa_pkg::out_word_t          out_word,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bsa_pkg::CFG_W-1:0]   cfg_data
);
  import bsa_pkg::*;

  localparam int ILIM_W = $clog2(INODE_SLOTS + 1);
  localparam int BLIM_W = $clog2(BLOCK_SLOTS + 1);
  localparam int ICMP_W = (ILIM_W > ILIM_REG_W) ? ILIM_W : ILIM_REG_W;
  localparam int BCMP_W = (BLIM_W > BLIM_REG_W) ? BLIM_W : BLIM_REG_W;
  localparam int IIDX_W = (INODE_SLOTS > 1) ? $clog2(INODE_SLOTS) : 1;
  localparam int BIDX_W = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WAIT = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t state;
  cmd_t pend_cmd;
  status_t res_status;
  logic [GRANT_W-1:0] res_grant;
  logic [ILIM_REG_W-1:0] inode_limit;
  logic [BLIM_REG_W-1:0] block_limit;
  logic [ICNT_W-1:0] inode_free;
  logic [BCNT_W-1:0] block_free;

  pool_req_t ireq, breq;
  pool_rsp_t irsp, brsp;
  logic [IIDX_W-1:0] igrant;
  logic [BIDX_W-1:0] bgrant;

  logic [ICMP_W-1:0] ilim_ext, cfg_ilim, cfg_ilim_eff, cfg_ilim_dec;
  logic [BCMP_W-1:0] blim_ext, cfg_blim, cfg_blim_eff;
  logic [ILIM_W-1:0] ilim_eff;
  logic [BLIM_W-1:0] blim_eff;
  logic [ICNT_W-1:0] inode_reload;
  logic [BCNT_W-1:0] block_reload;
  logic accept, in_range;
  cmd_t in_cmd;

  // Effective limits saturate at the pool sizes.
  assign ilim_ext = ICMP_W'(inode_limit);
  assign blim_ext = BCMP_W'(block_limit);
  assign ilim_eff = (ilim_ext > ICMP_W'(INODE_SLOTS)) ? ILIM_W'(INODE_SLOTS) : ILIM_W'(ilim_ext);
  assign blim_eff = (blim_ext > BCMP_W'(BLOCK_SLOTS)) ? BLIM_W'(BLOCK_SLOTS) : BLIM_W'(blim_ext);

  // Count reload values from the word being written.
  assign cfg_ilim     = ICMP_W'(cfg_data[ILIM_REG_W-1:0]);
  assign cfg_ilim_eff = (cfg_ilim > ICMP_W'(INODE_SLOTS)) ? ICMP_W'(INODE_SLOTS) : cfg_ilim;
  assign cfg_ilim_dec = (cfg_ilim_eff == '0) ? '0 : cfg_ilim_eff - ICMP_W'(1);
  assign inode_reload = (cfg_ilim_dec > ICMP_W'(INODE_CNT_MAX)) ? INODE_CNT_MAX
                                                                : ICNT_W'(cfg_ilim_dec);
  assign cfg_blim     = BCMP_W'(cfg_data[BLIM_REG_W-1:0]);
  assign cfg_blim_eff = (cfg_blim > BCMP_W'(BLOCK_SLOTS)) ? BCMP_W'(BLOCK_SLOTS) : cfg_blim;
  assign block_reload = (cfg_blim_eff > BCMP_W'(BLOCK_CNT_MAX)) ? BLOCK_CNT_MAX
                                                                : BCNT_W'(cfg_blim_eff);

  assign in_cmd   = cmd_t'(in_word.cmd);
  assign in_range = BCMP_W'(in_word.block_index) < BCMP_W'(blim_eff);
  assign in_stall = !(state == T_IDLE && irsp.ready && brsp.ready);
  assign accept   = in_valid && !in_stall;

  assign ireq.start   = accept && in_cmd == CMD_ALLOC_INODE;
  assign ireq.free_op = 1'b0;
  assign breq.start   = accept && (in_cmd == CMD_ALLOC_BLOCK ||
                                   (in_cmd == CMD_FREE_BLOCK && in_range));
  assign breq.free_op = in_cmd == CMD_FREE_BLOCK;

  bsa_pool #(
    .SLOTS (INODE_SLOTS),
    .FIRST (1)
  ) u_inode_pool (
    .clk         (clk),
    .rst         (rst),
    .req         (ireq),
    .limit       (ilim_eff),
    .index       ('0),
    .rsp         (irsp),
    .grant_index (igrant)
  );

  bsa_pool #(
    .SLOTS (BLOCK_SLOTS),
    .FIRST (0)
  ) u_block_pool (
    .clk         (clk),
    .rst         (rst),
    .req         (breq),
    .limit       (blim_eff),
    .index       (BIDX_W'(in_word.block_index)),
    .rsp         (brsp),
    .grant_index (bgrant)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      out_valid   <= 1'b0;
      inode_limit <= INODE_LIMIT_RST;
      block_limit <= BLOCK_LIMIT_RST;
      inode_free  <= INODE_CNT_RST;
      block_free  <= BLOCK_CNT_RST;
    end else begin
      if (state == T_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            case (in_cmd)
              CMD_ALLOC_INODE, CMD_ALLOC_BLOCK: begin
                state <= T_WAIT;
              end
              CMD_FREE_BLOCK: begin
                state <= in_range ? T_WAIT : T_OUT;
              end
              default: begin
                state <= T_OUT;
              end
            endcase
          end
        end
        T_WAIT: begin
          case (pend_cmd)
            CMD_ALLOC_INODE: begin
              if (irsp.done) begin
                state <= T_OUT;
                if (irsp.ok && inode_free != '0) begin
                  inode_free <= inode_free - ICNT_W'(1);
                end
              end
            end
            CMD_ALLOC_BLOCK: begin
              if (brsp.done) begin
                state <= T_OUT;
                if (brsp.ok && block_free != '0) begin
                  block_free <= block_free - BCNT_W'(1);
                end
              end
            end
            default: begin
              if (brsp.done) begin
                state <= T_OUT;
                if (brsp.ok && block_free != BLOCK_CNT_MAX) begin
                  block_free <= block_free + BCNT_W'(1);
                end
              end
            end
          endcase
        end
        T_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
      if (cfg_we) begin
        if (cfg_index == CFG_INODE_LIMIT) begin
          inode_limit <= cfg_data[ILIM_REG_W-1:0];
          inode_free  <= inode_reload;
        end else begin
          block_limit <= cfg_data[BLIM_REG_W-1:0];
          block_free  <= block_reload;
        end
      end
    end
  end

  // Result fields; the counts are sampled once the command has updated them.
  always_ff @(posedge clk) begin
    if (state == T_IDLE && accept) begin
      pend_cmd   <= in_cmd;
      res_status <= ST_INVALID;
      res_grant  <= '0;
    end
    if (state == T_WAIT) begin
      if (pend_cmd == CMD_ALLOC_INODE && irsp.done) begin
        res_status <= irsp.ok ? ST_OK : ST_NOSPACE;
        res_grant  <= irsp.ok ? GRANT_W'(igrant) : '0;
      end else if (pend_cmd == CMD_ALLOC_BLOCK && brsp.done) begin
        res_status <= brsp.ok ? ST_OK : ST_NOSPACE;
        res_grant  <= brsp.ok ? GRANT_W'(bgrant) : '0;
      end else if (pend_cmd == CMD_FREE_BLOCK && brsp.done) begin
        res_status <= brsp.ok ? ST_OK : ST_INVALID;
        res_grant  <= '0;
      end
    end
    if (state == T_OUT && (!out_valid || !out_stall)) begin
      out_word.status        <= res_status;
      out_word.granted_index <= res_grant;
      out_word.free_inodes   <= inode_free;
      out_word.free_blocks   <= block_free;
    end
  end

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for bitmap_slot_allocator: a directed table, then random phases.
// Results match the table or a behavioral predictor of both pools; depends on bsa_pkg.
`timescale 1ns / 1ps

module tb;
  import bsa_pkg::*;

  localparam int INODE_SLOTS = 256;
  localparam int BLOCK_SLOTS = 1024;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 170;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bitmap_slot_allocator #(
    .INODE_SLOTS(INODE_SLOTS),
    .BLOCK_SLOTS(BLOCK_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // Predicted allocator state.
  bit inode_map[INODE_SLOTS];
  bit block_map[BLOCK_SLOTS];
  logic [ICNT_W-1:0] inode_cnt;
  logic [BCNT_W-1:0] block_cnt;
  logic [ILIM_REG_W-1:0] inode_lim;
  logic [BLIM_REG_W-1:0] block_lim;

  out_word_t pending_results[$];
  int mismatches;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_left;

  typedef struct {
    bit is_cfg;
    logic cfg_idx;
    logic [CFG_W-1:0] cfg_val;
    in_word_t w;
    bit typed;
    out_word_t res;
  } row_t;

  row_t directed_rows[$];

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int inode_span();
    return (int'(inode_lim) > INODE_SLOTS) ? INODE_SLOTS : int'(inode_lim);
  endfunction

  function automatic int block_span();
    return (int'(block_lim) > BLOCK_SLOTS) ? BLOCK_SLOTS : int'(block_lim);
  endfunction

  // First-fit allocation and free with saturating counts, applied to the predicted state.
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int lim;
    bit found;
    r = '0;
    r.status = ST_INVALID;
    found = 1'b0;
    case (w.cmd)
      CMD_ALLOC_INODE: begin
        lim = inode_span();
        r.status = ST_NOSPACE;
        for (int i = 1; i < lim; i++) begin
          if (!found && !inode_map[i]) begin
            inode_map[i] = 1'b1;
            found = 1'b1;
            if (inode_cnt != 0) inode_cnt = inode_cnt - 1'b1;
            r.granted_index = GRANT_W'(i);
            r.status = ST_OK;
          end
        end
      end
      CMD_ALLOC_BLOCK: begin
        lim = block_span();
        r.status = ST_NOSPACE;
        for (int i = 0; i < lim; i++) begin
          if (!found && !block_map[i]) begin
            block_map[i] = 1'b1;
            found = 1'b1;
            if (block_cnt != 0) block_cnt = block_cnt - 1'b1;
            r.granted_index = GRANT_W'(i);
            r.status = ST_OK;
          end
        end
      end
      CMD_FREE_BLOCK: begin
        lim = block_span();
        if (int'(w.block_index) < lim && block_map[w.block_index]) begin
          block_map[w.block_index] = 1'b0;
          if (block_cnt != BLOCK_CNT_MAX) block_cnt = block_cnt + 1'b1;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.free_inodes = inode_cnt;
    r.free_blocks = block_cnt;
    return r;
  endfunction

  // Most frees target a block that is in use, found from a random starting point.
  function automatic logic [BIDX_IN_W-1:0] used_block();
    int lim;
    int start;
    int j;
    lim = block_span();
    start = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
    for (int n = 0; n < lim; n++) begin
      j = (start + n) % lim;
      if (block_map[j]) return BIDX_IN_W'(j);
    end
    return BIDX_IN_W'(start);
  endfunction

  function automatic in_word_t random_word(bit filling);
    in_word_t w;
    int roll;
    w.block_index = BIDX_IN_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      w.cmd = CMD_UNKNOWN;
    end else if (roll < 18) begin
      w.cmd = CMD_ALLOC_INODE;
    end else if (roll < (filling ? 70 : 40)) begin
      w.cmd = CMD_ALLOC_BLOCK;
    end else begin
      w.cmd = CMD_FREE_BLOCK;
      if (chance(80)) w.block_index = used_block();
    end
    return w;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int bidx, input bit typed,
                         input status_t st, input int gi, input int fi, input int fb);
    row_t row;
    row.is_cfg = 1'b0;
    row.cfg_idx = 1'b0;
    row.cfg_val = '0;
    row.w.cmd = cmd;
    row.w.block_index = BIDX_IN_W'(bidx);
    row.typed = typed;
    row.res.status = st;
    row.res.granted_index = GRANT_W'(gi);
    row.res.free_inodes = ICNT_W'(fi);
    row.res.free_blocks = BCNT_W'(fb);
    directed_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic idx, input logic [CFG_W-1:0] v);
    row_t row;
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = v;
    row.w = '0;
    row.typed = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t pred;
    while (chance(sender_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_command(w);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || in_stall);
  endtask

  // A limit write also reloads the matching free count; the bitmaps are kept.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
    int n;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == CFG_INODE_LIMIT) begin
      inode_lim = v[ILIM_REG_W-1:0];
      n = inode_span();
      n = (n > 0) ? n - 1 : 0;
      inode_cnt = (n > 255) ? INODE_CNT_MAX : ICNT_W'(n);
    end else begin
      block_lim = v[BLIM_REG_W-1:0];
      n = block_span();
      block_cnt = (n > 2047) ? BLOCK_CNT_MAX : BCNT_W'(n);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      mismatches++;
    end
  endtask

  // Result side: check each accepted word, then choose the stall for the next cycle.
  initial begin
    out_word_t want;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_word);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_word.status));
          compare_field("granted_index", 32'(want.granted_index),
                        32'(out_word.granted_index));
          compare_field("free_inodes", 32'(want.free_inodes), 32'(out_word.free_inodes));
          compare_field("free_blocks", 32'(want.free_blocks), 32'(out_word.free_blocks));
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= chance(recv_stall_pct);
      end
    end
  end

  initial begin
    row_t row;
    logic [CFG_W-1:0] iv;
    logic [CFG_W-1:0] bv;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    mismatches = 0;
    foreach (inode_map[i]) inode_map[i] = 1'b0;
    foreach (block_map[i]) block_map[i] = 1'b0;
    inode_lim = INODE_LIMIT_RST;
    block_lim = BLOCK_LIMIT_RST;
    inode_cnt = INODE_CNT_RST;
    block_cnt = BLOCK_CNT_RST;

    // Default limits straight after reset: first fit, double free, free of a clear bit.
    add_cmd(CMD_ALLOC_INODE, 1023, 1, ST_OK, 1, 254, 1024);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_OK, 0, 254, 1023);
    add_cmd(CMD_FREE_BLOCK, 0, 1, ST_OK, 0, 254, 1024);
    add_cmd(CMD_FREE_BLOCK, 0, 1, ST_INVALID, 0, 254, 1024);
    add_cmd(CMD_FREE_BLOCK, 1023, 1, ST_INVALID, 0, 254, 1024);
    add_cmd(CMD_UNKNOWN, 1023, 1, ST_INVALID, 0, 254, 1024);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_OK, 0, 254, 1023);
    add_cmd(CMD_ALLOC_BLOCK, 1023, 1, ST_OK, 1, 254, 1022);
    // Inode limits of zero and one leave no usable inode.
    add_cfg(CFG_INODE_LIMIT, 11'd0);
    add_cmd(CMD_ALLOC_INODE, 0, 1, ST_NOSPACE, 0, 0, 1022);
    add_cfg(CFG_INODE_LIMIT, 11'd1);
    add_cmd(CMD_ALLOC_INODE, 0, 1, ST_NOSPACE, 0, 0, 1022);
    // Limit two reloads a count of one, but inode one is taken already.
    add_cfg(CFG_INODE_LIMIT, 11'd2);
    add_cmd(CMD_ALLOC_INODE, 0, 1, ST_NOSPACE, 0, 1, 1022);
    // All ones saturates to the slot count.
    add_cfg(CFG_INODE_LIMIT, 11'h7FF);
    add_cmd(CMD_ALLOC_INODE, 0, 1, ST_OK, 2, 254, 1022);
    // One block slot: full pool, then a free beyond the limit of a used block.
    add_cfg(CFG_BLOCK_LIMIT, 11'd1);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_NOSPACE, 0, 254, 1);
    add_cmd(CMD_FREE_BLOCK, 1, 1, ST_INVALID, 0, 254, 1);
    add_cmd(CMD_FREE_BLOCK, 0, 1, ST_OK, 0, 254, 2);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_OK, 0, 254, 1);
    add_cfg(CFG_BLOCK_LIMIT, 11'd0);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_NOSPACE, 0, 254, 0);
    add_cmd(CMD_FREE_BLOCK, 0, 1, ST_INVALID, 0, 254, 0);
    // Reload with blocks in use lets the count drift above the bitmap.
    add_cfg(CFG_BLOCK_LIMIT, 11'h7FF);
    add_cmd(CMD_FREE_BLOCK, 1, 1, ST_OK, 0, 254, 1025);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_OK, 1, 254, 1024);
    add_cmd(CMD_ALLOC_BLOCK, 0, 1, ST_OK, 2, 254, 1023);
    add_cmd(CMD_FREE_BLOCK, 1023, 1, ST_INVALID, 0, 254, 1023);
    add_cmd(CMD_ALLOC_INODE, 512, 0, ST_OK, 0, 0, 0);
    add_cmd(CMD_FREE_BLOCK, 2, 0, ST_OK, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(row.cfg_idx, row.cfg_val);
      end else begin
        send_word(row.w, row.typed, row.res);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph % 5)
        0: begin
          iv = chance(50) ? 11'd256 : 11'h7FF;
          bv = chance(50) ? 11'd1024 : 11'h7FF;
        end
        1: begin
          iv = CFG_W'($urandom_range(0, 3));
          bv = CFG_W'($urandom_range(0, 3));
        end
        default: begin
          iv = CFG_W'($urandom_range(2, 40));
          bv = CFG_W'($urandom_range(1, 100));
        end
      endcase
      write_reg(CFG_INODE_LIMIT, iv);
      write_reg(CFG_BLOCK_LIMIT, bv);
      case (ph % 4)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          sender_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      // The receiver holds off while words keep coming, so the input backs up.
      if (ph == 2) hold_left = LONG_HOLD;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 5 && k == PHASE_WORDS / 2) drain();
        send_word(random_word(k < PHASE_WORDS / 2), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- bitmap_slot_allocator.f -----
sv/bsa_pkg.sv
sv/bsa_pool.sv
sv/bitmap_slot_allocator.sv
bench/tb.sv
